FILE: design/anc_pkg.sv
// ---------------------------------------------------------------------------
// anc_pkg: shared types and constants
// Holds the status codes and the request record that passes between the
// front and the back of the aperiodic necklace counter.
// ---------------------------------------------------------------------------
package anc_pkg;

   localparam int COUNT_BITS  = 63;
   localparam int STATUS_BITS = 2;
   localparam int LEN_BITS    = 6;

   typedef enum logic [STATUS_BITS-1:0] {
      STATUS_OK       = 2'd0,
      STATUS_BAD_ARG  = 2'd1,
      STATUS_OVERFLOW = 2'd2
   } status_type;

   // Classified request: the front has checked arguments; a bad request is
   // passed through with its bad flag so that ordering is kept.
   typedef struct packed {
      logic                bad;
      logic [7:0]          alphabet;
      logic [LEN_BITS-1:0] length;
   } job_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FACTOR,
      ST_POWER,
      ST_DIVIDE,
      ST_DONE
   } back_state_type;

endpackage

FILE: design/anc_front.sv
// ---------------------------------------------------------------------------
// anc_front: request intake and classification
// Accepts requests, checks the argument range and writes a job record into
// a short queue that feeds the back end.
// ---------------------------------------------------------------------------
module anc_front
   import anc_pkg::*;
#(
   parameter int MAX_WORD_LENGTH = 63,
   parameter int ALPHABET_BITS   = 8
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_push,
   output logic         req_full,
   input  logic [7:0]   req_alphabet_size,
   input  logic [5:0]   req_length,
   output logic         job_valid,
   output job_type      job,
   input  logic         job_take
);

   localparam int DEPTH = 2;

   job_type     mem_ff [DEPTH];
   logic        wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0]  cnt_ff, cnt_in;
   logic        push_ok, pop_ok;
   logic [7:0]  n_mask;
   job_type     nj;

   // Classify the incoming request.
   always_comb begin
      n_mask = req_alphabet_size & 8'((32'd1 << ALPHABET_BITS) - 32'd1);
      nj.alphabet = n_mask;
      nj.length   = req_length;
      nj.bad      = (n_mask < 8'd2) || (req_length == 6'd0) ||
                    (32'(req_length) > MAX_WORD_LENGTH);
   end

   assign req_full  = (cnt_ff == 2'(DEPTH));
   assign push_ok   = req_push && !req_full;
   assign job_valid = (cnt_ff != 2'd0);
   assign pop_ok    = job_take && job_valid;
   assign job       = mem_ff[rp_ff];

   // Queue pointers.
   always_comb begin
      wp_in  = push_ok ? ~wp_ff : wp_ff;
      rp_in  = pop_ok ? ~rp_ff : rp_ff;
      cnt_in = cnt_ff + 2'(push_ok) - 2'(pop_ok);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   // Queue storage.
   always_ff @(posedge clock) begin
      if (push_ok) begin
         mem_ff[wp_ff] <= nj;
      end
   end

endmodule

FILE: design/anc_back.sv
// ---------------------------------------------------------------------------
// anc_back: necklace count engine
// Factors the word length by trial division, accumulates the Moebius terms
// with one multiply per cycle, divides the sum by the length bit-serially
// and holds the result in an output register.
// ---------------------------------------------------------------------------
module anc_back
   import anc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  job_valid,
   input  job_type               job,
   output logic                  job_take,
   output logic                  rsp_empty,
   input  logic                  rsp_pop,
   output logic [COUNT_BITS-1:0] rsp_necklace_count,
   output logic [STATUS_BITS-1:0] rsp_status
);

   localparam logic [63:0] LIMIT = 64'h7FFF_FFFF_FFFF_FFFF;

   back_state_type state_ff, state_in;
   logic [7:0]  n_ff;
   logic [5:0]  len_ff;
   logic [5:0]  rest_ff, rest_in;
   logic [5:0]  div_ff, div_in;
   logic [5:0]  trem_ff, trem_in;
   logic [5:0]  tquo_ff, tquo_in;
   logic        trial_ff, trial_in;
   logic [2:0]  np_ff, np_in;
   logic [5:0]  primes_ff [3];
   logic [2:0]  mask_ff, mask_in;
   logic [5:0]  esum_ff, esum_in;
   logic [63:0] acc_ff, acc_in;
   logic        ovf_ff, ovf_in;
   logic [64:0] pos_ff, pos_in, neg_ff, neg_in;
   logic [64:0] rem_ff, rem_in;
   logic [63:0] quo_ff, quo_in;
   logic [6:0]  bit_ff, bit_in;
   logic        out_full_ff;
   logic [COUNT_BITS-1:0] out_cnt_ff;
   status_type  out_st_ff;
   logic        bad_ff;
   logic        start, finish;
   logic [71:0] prod;
   logic [11:0] div_sq;
   logic        factor_end;
   logic        prime_wr;
   logic [5:0]  prime_val;
   logic [1:0]  last_idx;
   logic [5:0]  dmul;
   logic        odd_sel;
   logic        last_mask;
   logic [64:0] diff;
   logic [5:0]  dbit;

   assign rsp_empty          = !out_full_ff;
   assign rsp_necklace_count = out_cnt_ff;
   assign rsp_status         = out_st_ff;
   assign start    = (state_ff == ST_IDLE) && job_valid && !out_full_ff;
   assign job_take = start;
   assign finish   = (state_ff == ST_DONE);

   // One multiply of the running power; the product is checked against the limit.
   assign prod = 72'(acc_ff) * 72'(n_ff);

   // Trial division stops once the candidate squared passes the rest; what is
   // left above one is then a prime of its own.
   assign div_sq     = 12'(div_ff) * 12'(div_ff);
   assign factor_end = !trial_ff && (div_sq > 12'(rest_ff));
   assign last_idx   = 2'(np_ff - 3'd1);

   // A prime is recorded when a trial divides evenly or when the rest is left
   // over at the end, unless it matches the prime recorded last.
   always_comb begin
      prime_val = factor_end ? rest_ff : div_ff;
      prime_wr  = 1'b0;
      if (state_ff == ST_FACTOR && np_ff < 3'd3) begin
         if (factor_end) prime_wr = (rest_ff > 6'd1);
         else if (trial_ff && trem_ff == 6'd0) prime_wr = 1'b1;
         if (np_ff != 3'd0 && primes_ff[last_idx] == prime_val) prime_wr = 1'b0;
      end
   end

   // Divisor product and sign for the current subset of primes (up to 3 primes for L<64).
   always_comb begin
      dmul    = 6'd1;
      odd_sel = 1'b0;
      for (int k = 0; k < 3; k++) begin
         if (mask_ff[k] && (3'(k) < np_ff)) begin
            dmul    = 6'(dmul * primes_ff[k]);
            odd_sel = ~odd_sel;
         end
      end
   end

   assign last_mask = (mask_ff == 3'((1 << np_ff) - 1));
   assign diff      = pos_ff - neg_ff;
   assign dbit      = 6'(bit_ff - 7'd1);

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (start) state_in = job.bad ? ST_DONE : ST_FACTOR;
         ST_FACTOR: if (factor_end) state_in = ST_POWER;
         ST_POWER:  if (esum_ff == len_ff && (ovf_ff || last_mask))
                       state_in = ovf_ff ? ST_DONE : ST_DIVIDE;
         ST_DIVIDE: if (bit_ff == 7'd0) state_in = ST_DONE;
         ST_DONE:   state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // Datapath updates.
   always_comb begin
      rest_in = rest_ff; div_in = div_ff; trem_in = trem_ff; tquo_in = tquo_ff;
      trial_in = trial_ff; np_in = np_ff; mask_in = mask_ff; esum_in = esum_ff;
      acc_in = acc_ff; ovf_in = ovf_ff;
      pos_in = pos_ff; neg_in = neg_ff; rem_in = rem_ff; quo_in = quo_ff;
      bit_in = bit_ff;
      unique case (state_ff)
         ST_IDLE: begin
            rest_in = job.length; div_in = 6'd2; trem_in = 6'd0; tquo_in = 6'd0;
            trial_in = 1'b0; np_in = 3'd0; esum_in = 6'd0;
            acc_in = 64'd1; ovf_in = 1'b0;
            mask_in = 3'd0; pos_in = '0; neg_in = '0;
         end
         ST_FACTOR: begin
            if (prime_wr) np_in = np_ff + 3'd1;
            // Each trial subtracts the candidate once a cycle, counting the quotient.
            if (!trial_ff) begin
               if (!factor_end) begin
                  trem_in  = rest_ff;
                  tquo_in  = 6'd0;
                  trial_in = 1'b1;
               end
            end else if (trem_ff >= div_ff) begin
               trem_in = trem_ff - div_ff;
               tquo_in = tquo_ff + 6'd1;
            end else begin
               trial_in = 1'b0;
               if (trem_ff == 6'd0) rest_in = tquo_ff;
               else                 div_in  = div_ff + 6'd1;
            end
         end
         ST_POWER: begin
            // The exponent L/d is reached when the running sum of d equals L.
            if (esum_ff != len_ff) begin
               if (prod > 72'(LIMIT)) ovf_in = 1'b1;
               acc_in  = prod[63:0];
               esum_in = esum_ff + dmul;
            end else if (!ovf_ff) begin
               if (odd_sel) neg_in = neg_ff + 65'(acc_ff);
               else         pos_in = pos_ff + 65'(acc_ff);
               mask_in = mask_ff + 3'd1;
               acc_in  = 64'd1;
               esum_in = 6'd0;
            end
            rem_in = '0; quo_in = '0; bit_in = 7'd64;
         end
         ST_DIVIDE: begin
            if (bit_ff != 7'd0) begin
               bit_in = {1'b0, dbit};
               rem_in = {rem_ff[63:0], diff[dbit]};
               if (rem_in >= 65'(len_ff)) begin
                  rem_in = rem_in - 65'(len_ff);
                  quo_in[dbit] = 1'b1;
               end
            end
         end
         default: ;
      endcase
   end

   // Prime list write, only when a new prime appears; alphabet and length are taken at start.
   always_ff @(posedge clock) begin
      if (prime_wr) begin
         primes_ff[np_ff[1:0]] <= prime_val;
      end
      if (start) begin
         n_ff   <= job.alphabet;
         len_ff <= job.length;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         out_full_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (finish) out_full_ff <= 1'b1;
         else if (rsp_pop && out_full_ff) out_full_ff <= 1'b0;
      end
      rest_ff <= rest_in; div_ff <= div_in; trem_ff <= trem_in; tquo_ff <= tquo_in;
      trial_ff <= trial_in; np_ff <= np_in; mask_ff <= mask_in; esum_ff <= esum_in;
      acc_ff <= acc_in; ovf_ff <= ovf_in;
      pos_ff <= pos_in; neg_ff <= neg_in; rem_ff <= rem_in; quo_ff <= quo_in;
      bit_ff <= bit_in;
   end

   // Result register; a job that never entered the engine is a bad argument.
   always_ff @(posedge clock) begin
      if (start) bad_ff <= job.bad;
      if (finish) begin
         if (bad_ff) begin
            out_st_ff <= STATUS_BAD_ARG;  out_cnt_ff <= '0;
         end else if (ovf_ff) begin
            out_st_ff <= STATUS_OVERFLOW; out_cnt_ff <= '0;
         end else begin
            out_st_ff <= STATUS_OK;       out_cnt_ff <= quo_ff[COUNT_BITS-1:0];
         end
      end
   end

endmodule

FILE: design/aperiodic_necklace_count_unit.sv
// ---------------------------------------------------------------------------
// aperiodic_necklace_count_unit: Lyndon word counter
// Top level joining the request front end and the count engine.
// ---------------------------------------------------------------------------
// A request with a bad argument skips the engine and goes straight to
// the result register. A valid request runs trial division of the length
// by repeated subtraction, with candidates only up to the square root of
// what is left; then one multiply per cycle for each power n^(L/d), each
// power then added into the signed sum for its square-free divisor; then
// a bit-serial restoring divide by L. An overflow skips the divide. The
// engine works on one request at a time and starts only while its result
// register is empty, so a result that is not popped holds the engine; the
// two-entry queue in front then takes two more requests before full rises.
module aperiodic_necklace_count_unit
   import anc_pkg::*;
#(
   parameter int MAX_WORD_LENGTH = 63,
   parameter int ALPHABET_BITS   = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_push,
   output logic                   req_full,
   input  logic [7:0]             req_alphabet_size,
   input  logic [5:0]             req_length,
   output logic                   rsp_empty,
   input  logic                   rsp_pop,
   output logic [COUNT_BITS-1:0]  rsp_necklace_count,
   output logic [STATUS_BITS-1:0] rsp_status
);

   logic    job_valid, job_take;
   job_type job;

   anc_front #(.MAX_WORD_LENGTH(MAX_WORD_LENGTH), .ALPHABET_BITS(ALPHABET_BITS)) u_front (
      .clock, .reset, .req_push, .req_full, .req_alphabet_size, .req_length,
      .job_valid, .job, .job_take
   );

   anc_back u_back (
      .clock, .reset, .job_valid, .job, .job_take,
      .rsp_empty, .rsp_pop, .rsp_necklace_count, .rsp_status
   );

endmodule

FILE: tb/aperiodic_necklace_count_unit_tb.sv
// ---------------------------------------------------------------------------
// aperiodic_necklace_count_unit_tb: regression for the Lyndon word counter
// Pushes directed and random requests through the queue-style ports, lets
// both sides idle at random, and checks each result against its own
// Witt-formula computation of the expected count and status.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module aperiodic_necklace_count_unit_tb;
   import anc_pkg::*;

   localparam int RANDOM_REQUESTS = 630;
   localparam logic [63:0] MAX63 = 64'h7FFF_FFFF_FFFF_FFFF;

   typedef struct {
      logic [7:0] alphabet_size;
      logic [5:0] length;
   } request_type;

   typedef struct {
      logic [COUNT_BITS-1:0] necklace_count;
      status_type            status;
   } count_type;

   logic                   clock;
   logic                   reset;
   logic                   req_push;
   logic                   req_full;
   logic [7:0]             req_alphabet_size;
   logic [5:0]             req_length;
   logic                   rsp_empty;
   logic                   rsp_pop;
   logic [COUNT_BITS-1:0]  rsp_necklace_count;
   logic [STATUS_BITS-1:0] rsp_status;

   request_type pending_requests[$];
   count_type   expected_counts[$];
   int          error_count;
   bit          stimulus_done;
   int          burst_left;
   int          gap_left;
   int          hold_left;
   int          pop_cycle;

   aperiodic_necklace_count_unit DUT (
      .clock(clock),
      .reset(reset),
      .req_push(req_push),
      .req_full(req_full),
      .req_alphabet_size(req_alphabet_size),
      .req_length(req_length),
      .rsp_empty(rsp_empty),
      .rsp_pop(rsp_pop),
      .rsp_necklace_count(rsp_necklace_count),
      .rsp_status(rsp_status)
   );

   initial clock = 1'b0;
   always #6 clock = ~clock;

   // Exact power with a flag when the value passes 2^63-1.
   function automatic bit checked_power(input logic [63:0] base, input int exponent,
                                        output logic [63:0] value);
      logic [63:0] acc;
      acc = 64'd1;
      for (int i = 0; i < exponent; i++) begin
         if (base != 0 && acc > MAX63 / base) return 1'b0;
         acc = acc * base;
      end
      value = acc;
      return 1'b1;
   endfunction

   // Witt formula: sum of mu(d) n^(L/d) over square-free divisors, over L.
   function automatic count_type lyndon_count(input request_type req);
      count_type   result;
      logic [63:0] n, full, term, pos, neg, d, quotient;
      int          len, rest, np, cnt;
      int          primes[8];
      n = {56'd0, req.alphabet_size};
      len = req.length;
      result.necklace_count = '0;
      result.status = STATUS_OK;
      np = 0;
      if (n < 2 || len < 1) begin
         result.status = STATUS_BAD_ARG;
         return result;
      end
      if (!checked_power(n, len, full)) begin
         result.status = STATUS_OVERFLOW;
         return result;
      end
      rest = len;
      for (int i = 2; i <= rest; i++) begin
         if (rest % i == 0) begin
            primes[np] = i;
            np++;
            while (rest % i == 0) rest = rest / i;
         end
      end
      pos = full;
      neg = 0;
      for (int mask = 1; mask < (1 << np); mask++) begin
         d = 1;
         cnt = 0;
         for (int k = 0; k < np; k++) begin
            if ((mask >> k) & 1) begin
               d = d * primes[k];
               cnt++;
            end
         end
         void'(checked_power(n, len / int'(d), term));
         if (cnt & 1) neg = neg + term;
         else pos = pos + term;
      end
      quotient = (pos - neg) / 64'(len);
      result.necklace_count = quotient[COUNT_BITS-1:0];
      return result;
   endfunction

   function automatic request_type make_request(input int n, input int len);
      request_type req;
      req.alphabet_size = n[7:0];
      req.length = len[5:0];
      return req;
   endfunction

   // Append one request to the pending queue.
   task automatic add_request(input int n, input int len);
      pending_requests = {pending_requests, make_request(n, len)};
   endtask

   // Fill the request queue: directed corners first, then random requests.
   initial begin
      int pick;
      error_count = 0;
      stimulus_done = 1'b0;
      add_request(0, 5);
      add_request(1, 10);
      add_request(2, 0);
      add_request(255, 0);
      add_request(2, 1);
      add_request(2, 2);
      add_request(2, 6);
      add_request(2, 30);
      add_request(2, 62);
      add_request(2, 63);
      add_request(3, 39);
      add_request(3, 40);
      add_request(255, 1);
      add_request(255, 7);
      add_request(255, 8);
      add_request(170, 42);
      add_request(85, 21);
      add_request(7, 60);
      add_request(2, 60);
      add_request(2, 42);
      for (int i = 0; i < RANDOM_REQUESTS; i++) begin
         pick = $urandom_range(0, 9);
         if (pick == 0)
            add_request($urandom_range(0, 255), $urandom_range(0, 63));
         else if (pick < 4)
            add_request(2, $urandom_range(1, 63));
         else if (pick < 7)
            add_request($urandom_range(2, 15), $urandom_range(1, 24));
         else
            add_request($urandom_range(2, 255), $urandom_range(1, 8));
      end
      reset = 1'b1;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
   end

   // Driver: offers requests in bursts with gaps in between.
   initial begin
      req_push = 1'b0;
      req_alphabet_size = '0;
      req_length = '0;
      burst_left = 0;
      gap_left = 0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_push && !req_full) begin
            expected_counts = {expected_counts,
                               lyndon_count(make_request(req_alphabet_size, req_length))};
            void'(pending_requests.pop_front());
         end
         if (req_push && req_full) begin
            // Keep offering the same request.
         end else if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            req_push <= 1'b0;
         end else if (pending_requests.size() > 0) begin
            request_type next_req;
            next_req = pending_requests[0];
            req_push <= 1'b1;
            req_alphabet_size <= next_req.alphabet_size;
            req_length <= next_req.length;
            if (burst_left > 0) begin
               burst_left <= burst_left - 1;
            end else begin
               burst_left <= $urandom_range(0, 12);
               gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 80);
            end
         end else begin
            req_push <= 1'b0;
            stimulus_done <= 1'b1;
         end
      end
   end

   // Monitor: pops on a stall pattern, with one long hold-off early on.
   initial begin
      rsp_pop = 1'b0;
      hold_left = 0;
      pop_cycle = 0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_pop && !rsp_empty) begin
            if (expected_counts.size() == 0) begin
               $error("necklace_count: result with no request waiting");
               error_count++;
            end else begin
               count_type want;
               want = expected_counts.pop_front();
               if (rsp_necklace_count !== want.necklace_count) begin
                  $error("necklace_count: expected %0d, actual %0d",
                         want.necklace_count, rsp_necklace_count);
                  error_count++;
               end
               if (rsp_status !== want.status) begin
                  $error("status: expected %0d, actual %0d", want.status, rsp_status);
                  error_count++;
               end
            end
         end
         pop_cycle <= pop_cycle + 1;
         if (pop_cycle == 300) hold_left <= 3000;
         if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            rsp_pop <= 1'b0;
         end else if (pop_cycle % 700 < 200) begin
            rsp_pop <= 1'b1;
         end else begin
            rsp_pop <= ($urandom_range(0, 3) != 0) && ((pop_cycle / 37) % 4 != 1);
         end
      end
   end

   // Wait for the drain, then a tail covering the engine latency.
   initial begin
      @(negedge reset);
      wait (stimulus_done && expected_counts.size() == 0);
      repeat (400) @(posedge clock);
      if (error_count == 0 && expected_counts.size() == 0) begin
         $display("aperiodic_necklace_count_unit regression: pass");
      end else begin
         $display("aperiodic_necklace_count_unit regression: fail");
      end
      $finish;
   end

   initial begin
      #20_000_000;
      $display("aperiodic_necklace_count_unit regression: fail");
      $finish;
   end

endmodule

FILE: files.f
design/anc_pkg.sv
design/anc_front.sv
design/anc_back.sv
design/aperiodic_necklace_count_unit.sv
tb/aperiodic_necklace_count_unit_tb.sv
